/* hw/rtl/sitrt_pkg.sv */
// Shared types, constants and microcode table for the radix text converter.
// Used by sitrt_div, sitrt_seq and the top level; depends on nothing.
`timescale 1ns / 1ps

package sitrt_pkg;

	localparam int ValueBits  = 32;
	localparam int MaxSymbols = 32;
	localparam int SymBits    = 8;
	localparam int SymRegs    = MaxSymbols / 8;
	localparam int DigitBits  = $clog2(MaxSymbols);
	localparam int CountBits  = DigitBits + 1;
	localparam int CfgBits    = 64;
	localparam int CfgIdxBits = 3;
	localparam int StepBits   = 4;
	localparam int DivChunk   = 4;
	localparam int DivCycles  = ValueBits / DivChunk;
	localparam int DivCntBits = $clog2(DivCycles);

	localparam logic [SymBits-1:0] MinusChar = 8'd45;
	localparam logic [SymBits-1:0] LowLimit  = 8'd32;
	localparam logic [SymBits-1:0] HighLimit = 8'd127;

	typedef enum logic [CfgIdxBits-1:0] {
		CFG_SYMBOL_COUNT = 3'd0,
		CFG_SYMBOLS_0    = 3'd1,
		CFG_SYMBOLS_1    = 3'd2,
		CFG_SYMBOLS_2    = 3'd3,
		CFG_SYMBOLS_3    = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_CHK_N,
		OP_CHK_SYM,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_PUSH,
		OP_SET_POS,
		OP_EMIT_SIGN,
		OP_EMIT_DIG,
		OP_EMIT_ERR
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_WAIT_IN,
		C_BAD,
		C_IDX_MORE,
		C_DIV_BUSY,
		C_MORE_DIGITS,
		C_POS_ZERO
	} cond_t;

	typedef struct packed {
		op_t                 op;
		cond_t               cond;
		logic [StepBits-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_acc;
		logic bad;
		logic idx_more;
		logic div_busy;
		logic more_digits;
		logic pos_zero;
		logic stall;
	} flags_t;

	localparam logic [StepBits-1:0] StepIdle  = 4'd0;
	localparam logic [StepBits-1:0] StepSym   = 4'd3;
	localparam logic [StepBits-1:0] StepDiv   = 4'd5;
	localparam logic [StepBits-1:0] StepStep  = 4'd6;
	localparam logic [StepBits-1:0] StepDig   = 4'd10;
	localparam logic [StepBits-1:0] StepErr   = 4'd12;
	localparam logic [StepBits-1:0] StepLast  = 4'd12;

	// Conversion program: alphabet check, divide loop, then emit loop; a bad alphabet jumps to the error item.
	function automatic ctrl_t ucode_rom(input logic [StepBits-1:0] step);
		ctrl_t w;
		unique case (step)
			4'd0:    w = '{OP_LOAD,      C_WAIT_IN,     StepIdle};
			4'd1:    w = '{OP_CHK_N,     C_NEVER,       StepIdle};
			4'd2:    w = '{OP_NOP,       C_BAD,         StepErr};
			4'd3:    w = '{OP_CHK_SYM,   C_IDX_MORE,    StepSym};
			4'd4:    w = '{OP_NOP,       C_BAD,         StepErr};
			4'd5:    w = '{OP_DIV_START, C_NEVER,       StepIdle};
			4'd6:    w = '{OP_DIV_STEP,  C_DIV_BUSY,    StepStep};
			4'd7:    w = '{OP_PUSH,      C_MORE_DIGITS, StepDiv};
			4'd8:    w = '{OP_SET_POS,   C_NEVER,       StepIdle};
			4'd9:    w = '{OP_EMIT_SIGN, C_NEVER,       StepIdle};
			4'd10:   w = '{OP_EMIT_DIG,  C_POS_ZERO,    StepIdle};
			4'd11:   w = '{OP_NOP,       C_ALWAYS,      StepDig};
			4'd12:   w = '{OP_EMIT_ERR,  C_ALWAYS,      StepIdle};
			default: w = '{OP_NOP,       C_ALWAYS,      StepIdle};
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/signed_integer_to_radix_text_unit.sv */
// Per item: alphabet check, then a divider pass per digit, then position and sign,
// then the emitted digits, most significant first.
// One item at a time: no new value is accepted until its last character is issued.
// An invalid alphabet gives a single flagged item.
// Reset clears control state and configuration; the digit stack is not cleared.
// Datapath and output register; depends on sitrt_pkg, sitrt_div and sitrt_seq.
`timescale 1ns / 1ps

module signed_integer_to_radix_text_unit
	import sitrt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CfgIdxBits-1:0] cfg_index,
	input  logic [CfgBits-1:0]    cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [ValueBits-1:0]  s_tdata,  // value_in
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [SymBits-1:0]    m_tdata,  // out_char
	output logic                  m_tlast,  // final_char
	output logic                  m_tuser   // bad_alphabet
);

	logic [CountBits-1:0] sym_count_q;
	logic [CfgBits-1:0]   sym_regs_q [SymRegs];

	logic [ValueBits-1:0] mag_q;
	logic                 neg_q;
	logic                 bad_q;
	logic [DigitBits-1:0] idx_q;
	logic [CountBits-1:0] digit_total_q;
	logic [DigitBits-1:0] pos_q;
	logic [DigitBits-1:0] rd_digit_q;
	logic [DigitBits-1:0] stack_mem [MaxSymbols];

	logic                 out_valid_q;
	logic [SymBits-1:0]   out_char_q;
	logic                 out_last_q;
	logic                 out_bad_q;

	ctrl_t                ctrl;
	flags_t               flags;
	logic                 in_acc;
	logic                 emit_req;
	logic                 out_free;
	logic                 emit;
	logic [SymBits-1:0]   cur_sym;
	logic                 sym_bad;
	logic [ValueBits-1:0] div_quot;
	logic [DigitBits-1:0] div_rem;
	logic                 div_busy;

	function automatic logic [SymBits-1:0] sym_at(input logic [CfgBits-1:0] regs [SymRegs],
			input logic [DigitBits-1:0] k);
		return regs[k[DigitBits-1:3]][k[2:0]*SymBits +: SymBits];
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_count_q <= '0;
			for (int i = 0; i < SymRegs; i++) begin
				sym_regs_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYMBOL_COUNT: sym_count_q   <= cfg_data[CountBits-1:0];
				CFG_SYMBOLS_0:    sym_regs_q[0] <= cfg_data;
				CFG_SYMBOLS_1:    sym_regs_q[1] <= cfg_data;
				CFG_SYMBOLS_2:    sym_regs_q[2] <= cfg_data;
				CFG_SYMBOLS_3:    sym_regs_q[3] <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign s_tready = (ctrl.op == OP_LOAD);
	assign in_acc   = s_tvalid && s_tready;

	// Check symbol idx_q: printable, not a minus, and unlike every earlier symbol.
	always_comb begin
		logic dup;
		cur_sym = sym_at(sym_regs_q, idx_q);
		dup     = 1'b0;
		for (int j = 0; j < MaxSymbols; j++) begin
			if (DigitBits'(j) < idx_q && sym_at(sym_regs_q, DigitBits'(j)) == cur_sym) begin
				dup = 1'b1;
			end
		end
		sym_bad = (cur_sym <= LowLimit) || (cur_sym >= HighLimit) || (cur_sym == MinusChar)
			|| dup;
	end

	assign emit_req = ((ctrl.op == OP_EMIT_SIGN) && neg_q) || (ctrl.op == OP_EMIT_DIG)
		|| (ctrl.op == OP_EMIT_ERR);
	assign out_free = !out_valid_q || m_tready;
	assign emit     = emit_req && out_free;

	always_comb begin
		flags.in_acc      = in_acc;
		flags.bad         = bad_q;
		flags.idx_more    = ({1'b0, idx_q} != (sym_count_q - 1'b1));
		flags.div_busy    = div_busy;
		flags.more_digits = (div_quot != '0) && (digit_total_q != CountBits'(MaxSymbols - 1));
		flags.pos_zero    = (pos_q == '0);
		flags.stall       = emit_req && !out_free;
	end

	sitrt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	sitrt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctrl.op == OP_DIV_START),
		.step      (ctrl.op == OP_DIV_STEP),
		.dividend  (mag_q),
		.base      (sym_count_q),
		.quotient  (div_quot),
		.remainder (div_rem),
		.busy      (div_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q         <= 1'b0;
			idx_q         <= '0;
			digit_total_q <= '0;
			pos_q         <= '0;
			neg_q         <= 1'b0;
		end else begin
			unique case (ctrl.op)
				OP_LOAD: begin
					if (in_acc) begin
						neg_q <= s_tdata[ValueBits-1];
					end
				end
				OP_CHK_N: begin
					bad_q         <= (sym_count_q < CountBits'(2))
						|| (sym_count_q > CountBits'(MaxSymbols));
					idx_q         <= '0;
					digit_total_q <= '0;
				end
				OP_CHK_SYM: begin
					bad_q <= bad_q || sym_bad;
					idx_q <= idx_q + 1'b1;
				end
				OP_PUSH:    digit_total_q <= digit_total_q + 1'b1;
				OP_SET_POS: pos_q <= DigitBits'(digit_total_q - 1'b1);
				OP_EMIT_DIG: begin
					if (emit) begin
						pos_q <= pos_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Magnitude: two's complement negate, unsigned, so the most negative value fits.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_q <= s_tdata[ValueBits-1] ? (~s_tdata + 1'b1) : s_tdata;
		end else if (ctrl.op == OP_PUSH) begin
			mag_q <= div_quot;
		end
	end

	// Digit stack, least significant first; registered read at pos_q.
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_PUSH) begin
			stack_mem[digit_total_q[DigitBits-1:0]] <= div_rem;
		end
		rd_digit_q <= stack_mem[pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			unique case (ctrl.op)
				OP_EMIT_SIGN: begin
					out_char_q <= MinusChar;
					out_last_q <= 1'b0;
					out_bad_q  <= 1'b0;
				end
				OP_EMIT_DIG: begin
					out_char_q <= sym_at(sym_regs_q, rd_digit_q);
					out_last_q <= (pos_q == '0);
					out_bad_q  <= 1'b0;
				end
				default: begin
					out_char_q <= '0;
					out_last_q <= 1'b1;
					out_bad_q  <= 1'b1;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("item taken while converting");

	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
		else $error("flagged item malformed");

	a_digit_total: assert property (@(posedge clk) disable iff (!arst_n)
		digit_total_q <= CountBits'(MaxSymbols))
		else $error("digit count overflow");

	a_char_printable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata > LowLimit && m_tdata < HighLimit))
		else $error("emitted character outside printable range");

endmodule

/* hw/rtl/sitrt_div.sv */
// Iterative divider of the magnitude by the base, DivChunk quotient bits a cycle.
// Depends on sitrt_pkg.
`timescale 1ns / 1ps

module sitrt_div
	import sitrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 step,
	input  logic [ValueBits-1:0] dividend,
	input  logic [CountBits-1:0] base,
	output logic [ValueBits-1:0] quotient,
	output logic [DigitBits-1:0] remainder,
	output logic                 busy
);

	logic [ValueBits-1:0]  quot_q;
	logic [CountBits-1:0]  rem_q;
	logic [DivCntBits-1:0] cnt_q;
	logic [ValueBits-1:0]  quot_d;
	logic [CountBits-1:0]  rem_d;

	// Restoring steps; the remainder stays below the base, so each step is narrow.
	always_comb begin
		logic [CountBits-1:0] t;
		quot_d = quot_q;
		rem_d  = rem_q;
		for (int k = 0; k < DivChunk; k++) begin
			t = {rem_d[CountBits-2:0], quot_d[ValueBits-1]};
			if (t >= base) begin
				rem_d  = t - base;
				quot_d = {quot_d[ValueBits-2:0], 1'b1};
			end else begin
				rem_d  = t;
				quot_d = {quot_d[ValueBits-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (step) begin
			quot_q <= quot_d;
			rem_q  <= rem_d;
		end
	end

	assign quotient  = quot_q;
	assign remainder = rem_q[DigitBits-1:0];
	assign busy      = (cnt_q != DivCntBits'(DivCycles - 1));

endmodule

/* hw/rtl/sitrt_seq.sv */
// Microcode sequencer: step counter, control word lookup and conditional jumps.
// Depends on sitrt_pkg for the control word, flags and program table.
`timescale 1ns / 1ps

module sitrt_seq
	import sitrt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  flags_t flags,
	output ctrl_t  ctrl
);

	logic [StepBits-1:0] step_q;
	logic [StepBits-1:0] step_d;
	logic                jump;

	assign ctrl = ucode_rom(step_q);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:       jump = 1'b0;
			C_ALWAYS:      jump = 1'b1;
			C_WAIT_IN:     jump = !flags.in_acc;
			C_BAD:         jump = flags.bad;
			C_IDX_MORE:    jump = flags.idx_more;
			C_DIV_BUSY:    jump = flags.div_busy;
			C_MORE_DIGITS: jump = flags.more_digits;
			C_POS_ZERO:    jump = flags.pos_zero;
			default:       jump = 1'b0;
		endcase
		// Hold the step while the output slot is full.
		if (flags.stall) begin
			step_d = step_q;
		end else if (jump) begin
			step_d = ctrl.target;
		end else begin
			step_d = step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StepIdle;
		end else begin
			step_q <= step_d;
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= StepLast)
		else $error("sequencer step beyond program");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		flags.stall |=> step_q == $past(step_q))
		else $error("step moved while output stalled");

	a_wait_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == StepIdle && !flags.in_acc) |=> step_q == StepIdle)
		else $error("left idle without an item");

endmodule

/* tb/radix_text_checker.sv */
// Scoreboard for the signed integer to radix text converter: watches the configuration
// port and both stream channels, predicts each emitted character and compares it.
// Depends on sitrt_pkg for widths and character limits.
`timescale 1ns / 1ps

module radix_text_checker
	import sitrt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CfgIdxBits-1:0] cfg_index,
	input  logic [CfgBits-1:0]    cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [ValueBits-1:0]  s_tdata,  // value_in
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [SymBits-1:0]    m_tdata,  // out_char
	input  logic                  m_tlast,  // final_char
	input  logic                  m_tuser,  // bad_alphabet
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct packed {
		logic [SymBits-1:0] out_char;
		logic               final_char;
		logic               bad_alphabet;
	} text_char_t;

	text_char_t pending_text[$];

	logic [CountBits-1:0] base_copy;
	logic [CfgBits-1:0]   symbol_bank [SymRegs];
	int                   errors;

	function automatic logic [SymBits-1:0] symbol_byte(input int k);
		return symbol_bank[k / 8][(k % 8) * SymBits +: SymBits];
	endfunction

	function automatic bit alphabet_valid();
		int                 n;
		logic [SymBits-1:0] s;
		n = base_copy;
		if (n < 2 || n > MaxSymbols)
			return 1'b0;
		for (int a = 0; a < n; a++) begin
			s = symbol_byte(a);
			if (s <= LowLimit || s >= HighLimit || s == MinusChar)
				return 1'b0;
			for (int b = a + 1; b < n; b++)
				if (symbol_byte(b) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Queue the characters one number turns into under the current alphabet.
	task automatic spell_value(input logic [ValueBits-1:0] raw);
		logic [ValueBits-1:0] mag;
		logic [ValueBits-1:0] radix;
		logic [DigitBits-1:0] digits [MaxSymbols];
		int                   cnt;
		if (!alphabet_valid()) begin
			pending_text.push_back('{'0, 1'b1, 1'b1});
			return;
		end
		radix = ValueBits'(base_copy);
		mag = raw[ValueBits-1] ? ~raw + 1'b1 : raw;
		cnt = 0;
		do begin
			digits[cnt] = DigitBits'(mag % radix);
			mag = mag / radix;
			cnt++;
		end while (mag != 0 && cnt < MaxSymbols);
		if (raw[ValueBits-1])
			pending_text.push_back('{MinusChar, 1'b0, 1'b0});
		for (int d = cnt - 1; d >= 0; d--)
			pending_text.push_back('{symbol_byte(digits[d]), d == 0, 1'b0});
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			base_copy = '0;
			for (int r = 0; r < SymRegs; r++)
				symbol_bank[r] = '0;
			pending_text.delete();
			errors = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_text.size() == 0) begin
					$error("unexpected item: out_char %0d final_char %0d bad_alphabet %0d",
						m_tdata, m_tlast, m_tuser);
					errors++;
				end else begin
					want = pending_text.pop_front();
					if (m_tdata !== want.out_char) begin
						$error("out_char: expected %0d, actual %0d", want.out_char, m_tdata);
						errors++;
					end
					if (m_tlast !== want.final_char) begin
						$error("final_char: expected %0d, actual %0d", want.final_char, m_tlast);
						errors++;
					end
					if (m_tuser !== want.bad_alphabet) begin
						$error("bad_alphabet: expected %0d, actual %0d",
							want.bad_alphabet, m_tuser);
						errors++;
					end
				end
			end
			// predict with the alphabet in force before this edge
			if (s_tvalid && s_tready)
				spell_value(s_tdata);
			if (cfg_we) begin
				case (cfg_index)
					CFG_SYMBOL_COUNT: base_copy = cfg_data[CountBits-1:0];
					CFG_SYMBOLS_0:    symbol_bank[0] = cfg_data;
					CFG_SYMBOLS_1:    symbol_bank[1] = cfg_data;
					CFG_SYMBOLS_2:    symbol_bank[2] = cfg_data;
					CFG_SYMBOLS_3:    symbol_bank[3] = cfg_data;
					default: ;
				endcase
			end
			mismatches <= errors;
			outstanding <= pending_text.size();
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the radix text converter bench: clock, reset, alphabet programming, number
// stimulus with random gaps and back-pressure, watchdog and verdict.
// Depends on sitrt_pkg, signed_integer_to_radix_text_unit and radix_text_checker.
`timescale 1ns / 1ps

module testbench;
	import sitrt_pkg::*;

	localparam int TotalItems    = 320;
	localparam int HoldCycles    = 600;
	localparam int SettleCycles  = 8;
	localparam int EndCycles     = 40;
	localparam int WatchdogLimit = 4000;
	localparam int CfgIdxTop     = (1 << CfgIdxBits) - 1;
	localparam int PoolSize      = 93;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CfgIdxBits-1:0] cfg_index;
	logic [CfgBits-1:0]    cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [ValueBits-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [SymBits-1:0]    m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	int mismatches;
	int outstanding;
	int sent;
	int idle_cycles;
	bit burst;
	int hold_asks;

	logic [SymBits-1:0] alpha [MaxSymbols];
	logic [SymBits-1:0] pool [PoolSize];

	signed_integer_to_radix_text_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	radix_text_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Fill the alphabet with text, junk in the bytes past its end.
	task automatic set_alpha_text(input string s);
		for (int i = 0; i < MaxSymbols; i++)
			alpha[i] = (i < s.len()) ? s[i] : SymBits'($urandom_range(0, 255));
	endtask

	// Program every index, the unused ones too, with the count and current alphabet.
	task automatic write_alphabet(input logic [CountBits-1:0] count);
		logic [CfgBits-1:0] word;
		cfg_we <= 1'b1;
		for (int r = 0; r <= CfgIdxTop; r++) begin
			word = {$urandom, $urandom};
			if (r == CFG_SYMBOL_COUNT)
				word[CountBits-1:0] = count;
			else if (r <= CFG_SYMBOLS_3)
				for (int b = 0; b < 8; b++)
					word[b * SymBits +: SymBits] = alpha[(r - CFG_SYMBOLS_0) * 8 + b];
			cfg_index <= CfgIdxBits'(r);
			cfg_data <= word;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_value(input logic [ValueBits-1:0] v);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Drop valid, wait for every expected item, then let the block go idle.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Receiver: random stall before each item, a long hold-off when asked.
	initial begin
		int stall;
		int holds;
		holds = 0;
		m_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (holds < hold_asks) begin
				stall = HoldCycles;
				holds++;
			end else begin
				stall = burst ? 0 : $urandom_range(0, 13);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("signed_integer_to_radix_text_unit verification failed");
			$finish;
		end
	end

	initial begin
		int                   k;
		int                   n;
		int                   j;
		int                   p;
		int                   count_items;
		logic [CountBits-1:0] cur_count;
		logic [ValueBits-1:0] v;
		logic [ValueBits-1:0] pw;
		logic [SymBits-1:0]   tmp;
		logic [15:0]          half;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		sent = 0;
		burst = 1'b0;
		hold_asks = 0;
		k = 0;
		for (int c = LowLimit + 1; c < HighLimit; c++)
			if (c != MinusChar) begin
				pool[k] = SymBits'(c);
				k++;
			end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// decimal, with a minus sign and a zero byte among the ignored bytes
		set_alpha_text("0123456789");
		alpha[10] = MinusChar;
		alpha[11] = '0;
		write_alphabet(CountBits'(10));
		send_value(32'd0);
		send_value(32'd1);
		send_value(32'hFFFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd10);
		send_value(-32'sd10);
		send_value(32'd9);
		settle();

		// smallest base: the most negative number gives sign plus 32 digits
		set_alpha_text("01");
		write_alphabet(CountBits'(2));
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		settle();

		set_alpha_text("0123456789ABCDEFGHIJKLMNOPQRSTUV");
		write_alphabet(CountBits'(MaxSymbols));
		send_value(32'h8000_0000);
		send_value(32'd31);
		send_value(32'd32);
		settle();

		// first and last printable symbols
		set_alpha_text("!123456789abcde~");
		write_alphabet(CountBits'(16));
		send_value(32'hDEAD_BEEF);
		send_value(32'd255);
		settle();

		// invalid alphabets: one flagged item each
		set_alpha_text("0123456789ABCDEFGHIJKLMNOPQRSTUV");
		write_alphabet(CountBits'(0));
		send_value(32'd5);
		settle();
		write_alphabet(CountBits'(1));
		send_value(32'h8000_0000);
		settle();
		write_alphabet(CountBits'(MaxSymbols + 1));
		send_value(32'd7);
		settle();
		write_alphabet('1);
		send_value(32'hFFFF_FFFF);
		settle();
		set_alpha_text("0123456789");
		alpha[0] = LowLimit;
		write_alphabet(CountBits'(10));
		send_value(32'd3);
		settle();
		set_alpha_text("0123456789");
		alpha[9] = HighLimit;
		write_alphabet(CountBits'(10));
		send_value(32'd3);
		settle();
		set_alpha_text("0123456789");
		alpha[4] = MinusChar;
		write_alphabet(CountBits'(10));
		send_value(32'd3);
		settle();
		set_alpha_text("0123456789");
		alpha[2] = 8'h80;
		write_alphabet(CountBits'(10));
		send_value(32'd3);
		settle();
		set_alpha_text("0123456789");
		alpha[7] = 8'hFF;
		write_alphabet(CountBits'(10));
		send_value(32'd3);
		settle();
		set_alpha_text("0123456789");
		alpha[9] = alpha[0];
		write_alphabet(CountBits'(10));
		send_value(32'd3);
		settle();

		p = 0;
		while (sent < TotalItems) begin
			// fresh random alphabet, mostly valid
			for (int i = 0; i < MaxSymbols; i++) begin
				j = $urandom_range(i, PoolSize - 1);
				tmp = pool[i];
				pool[i] = pool[j];
				pool[j] = tmp;
				alpha[i] = pool[i];
			end
			n = $urandom_range(2, MaxSymbols);
			for (int i = n; i < MaxSymbols; i++)
				alpha[i] = SymBits'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < 15) begin
				case ($urandom_range(0, 3))
					0: n = $urandom_range(0, 1);
					1: n = $urandom_range(MaxSymbols + 1, (1 << CountBits) - 1);
					2: begin
						j = $urandom_range(0, n - 1);
						case ($urandom_range(0, 2))
							0: alpha[j] = SymBits'($urandom_range(0, LowLimit));
							1: alpha[j] = MinusChar;
							default: alpha[j] = SymBits'($urandom_range(HighLimit, 255));
						endcase
					end
					default: begin
						j = $urandom_range(1, n - 1);
						alpha[j] = alpha[$urandom_range(0, j - 1)];
					end
				endcase
			end
			cur_count = CountBits'(n);
			write_alphabet(cur_count);

			burst = ($urandom_range(0, 3) == 0);
			if (p == 1) begin
				// hold the receiver while items keep coming back to back
				burst = 1'b1;
				hold_asks++;
			end
			count_items = $urandom_range(8, 24);
			for (int i = 0; i < count_items; i++) begin
				if (p == 3 && i == count_items / 2)
					settle();
				case ($urandom_range(0, 9))
					0, 1, 2, 3: v = $urandom;
					4, 5:       v = $urandom_range(0, 99);
					6:          v = 32'd0 - $urandom_range(1, 99);
					7: begin
						case ($urandom_range(0, 3))
							0:       v = 32'h8000_0000;
							1:       v = 32'h7FFF_FFFF;
							2:       v = 32'hFFFF_FFFF;
							default: v = 32'h8000_0001;
						endcase
					end
					8: begin
						pw = 32'd1;
						repeat ($urandom_range(0, 31)) pw = pw * cur_count;
						v = pw - $urandom_range(0, 1);
						if ($urandom_range(0, 1))
							v = 32'd0 - v;
					end
					default: begin
						half = 16'($urandom);
						v = {{16{half[15]}}, half};
					end
				endcase
				send_value(v);
			end
			settle();
			p++;
		end

		repeat (EndCycles) @(posedge clk);
		if (mismatches == 0)
			$display("signed_integer_to_radix_text_unit verification clean");
		else
			$display("signed_integer_to_radix_text_unit verification failed");
		$finish;
	end

endmodule
